>>> hdl/rbst_pkg.sv
// Shared types and constants for the ray versus box slab test.
`timescale 1ns / 1ps
package rbst_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned NUM_W    = WORD_W + 1;
  localparam int unsigned REM_W    = 2 * WORD_W;
  localparam int unsigned NUM_AXES = 3;
  localparam int unsigned NUM_LANE = 2 * NUM_AXES;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic signed [WORD_W-1:0] SAT_HI = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic signed [WORD_W-1:0] SAT_LO = {1'b1, {(WORD_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BOX_MIN_X = 3'd0,
    REG_BOX_MIN_Y = 3'd1,
    REG_BOX_MIN_Z = 3'd2,
    REG_BOX_MAX_X = 3'd3,
    REG_BOX_MAX_Y = 3'd4,
    REG_BOX_MAX_Z = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic dzero;
    logic nneg;
    logic neg;
    logic ovf;
  } lane_flags_t;

endpackage

>>> hdl/ray_box_slab_test.sv
// Top level: pipelined ray versus axis-aligned box slab test.
//
// channel  ports                                    handshake
// -------  ---------------------------------------  -------------------------
// in       in_origin_*, in_dir_*                    start & !busy
// out      out_gap, out_hit                         out_valid, one cycle each
// cfg      cfg_we, cfg_index, cfg_wdata             cfg_we, no wait
//
// One request enters every cycle. The pipeline holds six dividers that make one
// quotient bit per stage (32 stages) plus input, finish, min/max, reduce and output
// stages. busy is always low.
// Synchronous reset clears the box registers and all valid bits.
// The receiver cannot stall, so the pipeline never holds.
`timescale 1ns / 1ps
module ray_box_slab_test (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [rbst_pkg::WORD_W-1:0]   in_origin_x,
  input  logic signed [rbst_pkg::WORD_W-1:0]   in_origin_y,
  input  logic signed [rbst_pkg::WORD_W-1:0]   in_origin_z,
  input  logic signed [rbst_pkg::WORD_W-1:0]   in_dir_x,
  input  logic signed [rbst_pkg::WORD_W-1:0]   in_dir_y,
  input  logic signed [rbst_pkg::WORD_W-1:0]   in_dir_z,
  output logic                                 out_valid,
  output logic signed [rbst_pkg::WORD_W-1:0]   out_gap,
  output logic                                 out_hit,
  input  logic                                 cfg_we,
  input  logic [rbst_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rbst_pkg::WORD_W-1:0]          cfg_wdata
);
  import rbst_pkg::*;

  logic signed [WORD_W-1:0] box_r [NUM_LANE];
  logic signed [WORD_W-1:0] org   [NUM_AXES];
  logic signed [WORD_W-1:0] dir   [NUM_AXES];

  logic              v_r   [WORD_W+1];
  logic [REM_W-1:0]  rem_r [NUM_LANE][WORD_W+1];
  logic [WORD_W-1:0] dm_r  [NUM_LANE][WORD_W+1];
  logic [WORD_W-1:0] q_r   [NUM_LANE][WORD_W+1];
  lane_flags_t       fl_r  [NUM_LANE][WORD_W+1];

  logic                     t_v_r;
  logic signed [WORD_W-1:0] t_r    [NUM_LANE];
  logic signed [WORD_W-1:0] t_nxt  [NUM_LANE];
  logic                     nf_v_r;
  logic signed [WORD_W-1:0] near_r [NUM_AXES];
  logic signed [WORD_W-1:0] far_r  [NUM_AXES];
  logic                     ex_v_r;
  logic signed [WORD_W-1:0] enter_r, exit_r, enter_nxt, exit_nxt;
  logic signed [WORD_W:0]   diff;
  logic signed [WORD_W-1:0] gap_nxt;

  assign busy = 1'b0;
  assign org[0] = in_origin_x;
  assign org[1] = in_origin_y;
  assign org[2] = in_origin_z;
  assign dir[0] = in_dir_x;
  assign dir[1] = in_dir_y;
  assign dir[2] = in_dir_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LANE; i++) box_r[i] <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BOX_MIN_X: box_r[0] <= cfg_wdata;
        REG_BOX_MIN_Y: box_r[1] <= cfg_wdata;
        REG_BOX_MIN_Z: box_r[2] <= cfg_wdata;
        REG_BOX_MAX_X: box_r[3] <= cfg_wdata;
        REG_BOX_MAX_Y: box_r[4] <= cfg_wdata;
        REG_BOX_MAX_Z: box_r[5] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // valid chain through the divider stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= WORD_W; k++) v_r[k] <= 1'b0;
    end else begin
      v_r[0] <= start & ~busy;
      for (int k = 0; k < WORD_W; k++) v_r[k+1] <= v_r[k];
    end
  end

  genvar j, k;
  generate
    for (j = 0; j < NUM_LANE; j++) begin : g_lane
      logic signed [NUM_W-1:0] num;
      logic [NUM_W-1:0]        nmag;
      logic [WORD_W-1:0]       dmag;
      logic signed [WORD_W-1:0] d;
      lane_flags_t             fl_nxt;

      always_comb begin
        d      = dir[j % NUM_AXES];
        num    = NUM_W'(box_r[j]) - NUM_W'(org[j % NUM_AXES]);
        nmag   = num[NUM_W-1] ? -num : num;
        dmag   = d[WORD_W-1] ? -d : d;
        fl_nxt.dzero = (d == '0);
        fl_nxt.nneg  = ~num[NUM_W-1];
        fl_nxt.neg   = num[NUM_W-1] ^ d[WORD_W-1];
        fl_nxt.ovf   = ({{(REM_W-NUM_W-FRAC_W){1'b0}}, nmag, {FRAC_W{1'b0}}}
                        >= {dmag, {WORD_W{1'b0}}});
      end

      always_ff @(posedge clk) begin
        rem_r[j][0] <= {{(REM_W-NUM_W-FRAC_W){1'b0}}, nmag, {FRAC_W{1'b0}}};
        dm_r[j][0]  <= dmag;
        q_r[j][0]   <= '0;
        fl_r[j][0]  <= fl_nxt;
      end

      for (k = 0; k < WORD_W; k++) begin : g_stage
        logic [REM_W-1:0] trial;
        logic             ge;
        always_comb begin
          trial = {{WORD_W{1'b0}}, dm_r[j][k]} << (WORD_W - 1 - k);
          ge    = (rem_r[j][k] >= trial);
        end
        always_ff @(posedge clk) begin
          rem_r[j][k+1] <= ge ? rem_r[j][k] - trial : rem_r[j][k];
          dm_r[j][k+1]  <= dm_r[j][k];
          q_r[j][k+1]   <= {q_r[j][k][WORD_W-2:0], ge};
          fl_r[j][k+1]  <= fl_r[j][k];
        end
      end

      always_comb begin
        if (fl_r[j][WORD_W].dzero) begin
          t_nxt[j] = fl_r[j][WORD_W].nneg ? SAT_HI : SAT_LO;
        end else if (!fl_r[j][WORD_W].neg) begin
          t_nxt[j] = (fl_r[j][WORD_W].ovf || q_r[j][WORD_W][WORD_W-1]) ?
                     SAT_HI : q_r[j][WORD_W];
        end else begin
          t_nxt[j] = (fl_r[j][WORD_W].ovf || (q_r[j][WORD_W] > SAT_LO)) ?
                     SAT_LO : -q_r[j][WORD_W];
        end
      end

      always_ff @(posedge clk) begin
        t_r[j] <= t_nxt[j];
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    for (int a = 0; a < NUM_AXES; a++) begin
      near_r[a] <= (t_r[a] < t_r[a+NUM_AXES]) ? t_r[a] : t_r[a+NUM_AXES];
      far_r[a]  <= (t_r[a] > t_r[a+NUM_AXES]) ? t_r[a] : t_r[a+NUM_AXES];
    end
  end

  always_comb begin
    enter_nxt = '0;
    exit_nxt  = SAT_HI;
    for (int a = 0; a < NUM_AXES; a++) begin
      if (near_r[a] > enter_nxt) enter_nxt = near_r[a];
      if (far_r[a] < exit_nxt) exit_nxt = far_r[a];
    end
  end

  always_ff @(posedge clk) begin
    enter_r <= enter_nxt;
    exit_r  <= exit_nxt;
  end

  always_comb begin
    diff = (WORD_W+1)'(enter_r) - (WORD_W+1)'(exit_r);
    if (diff > (WORD_W+1)'(SAT_HI)) gap_nxt = SAT_HI;
    else if (diff < (WORD_W+1)'(SAT_LO)) gap_nxt = SAT_LO;
    else gap_nxt = diff[WORD_W-1:0];
  end

  always_ff @(posedge clk) begin
    out_gap <= gap_nxt;
    out_hit <= (gap_nxt <= 0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_v_r     <= 1'b0;
      nf_v_r    <= 1'b0;
      ex_v_r    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      t_v_r     <= v_r[WORD_W];
      nf_v_r    <= t_v_r;
      ex_v_r    <= nf_v_r;
      out_valid <= ex_v_r;
    end
  end

endmodule
